>>> hw/rtl/pba_pkg.sv
`default_nettype none
package pba_pkg;
    localparam int NumPagesDef  = 131072;
    localparam int PageBytesDef = 4096;
    localparam int CntW         = 18;
    localparam int AddrOutW     = 29;

    localparam logic [1:0] OpAdd   = 2'd0;
    localparam logic [1:0] OpAlloc = 2'd1;
    localparam logic [1:0] OpRun   = 2'd2;
    localparam logic [1:0] OpFree  = 2'd3;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StNoFree = 2'd1;
    localparam logic [1:0] StBadFree = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_ONE_RD, S_ONE_CHK, S_RUN_RD,
        S_RUN_CHK, S_RUN_SKIP, S_CLR_RD, S_CLR_WR, S_FREE_RD, S_FREE_CHK, S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/pba_ram.sv
`default_nettype none
module pba_ram #(
    parameter int Width = 64,
    parameter int Depth = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/page_bitmap_allocator.sv
`default_nettype none
// Bitmap page allocator: one free bit per page held in a 64-bit-wide RAM.
// Input channel (i_valid / o_stall): op, address, region_length,
// region_usable, run_pages, align_bytes. Output channel (o_valid /
// i_stall): status, page_address, free_count, total_count, one word per
// input word. One word is worked on at a time; o_stall is high while busy.
// Every map access after the clearing pass is a RAM read state followed by a
// test or write-back state. Add region: a read and a write-back per page added.
// Allocate one: a read and a test per word scanned, then a read and a
// write-back to take the page. Allocate run: a read and a test per page tested,
// a skip step per alignment step after a used page, a read and a write-back per
// page taken. Free: a read, then a test and write-back. Each word is accepted in
// the idle state and ends in the result state. After reset a clearing pass
// writes zero to each map word, one word per cycle, during which no input is
// accepted. The result sits in an output register until taken; while the
// receiver stalls, o_stall stays high and no new word is accepted.
module page_bitmap_allocator #(
    parameter int NUM_PAGES  = pba_pkg::NumPagesDef,
    parameter int PAGE_BYTES = pba_pkg::PageBytesDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_address,
    input  wire logic [63:0] i_region_length,
    input  wire logic        i_region_usable,
    input  wire logic [17:0] i_run_pages,
    input  wire logic [29:0] i_align_bytes,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [pba_pkg::AddrOutW-1:0] o_page_address,
    output logic [pba_pkg::CntW-1:0]     o_free_count,
    output logic [pba_pkg::CntW-1:0]     o_total_count
);
    import pba_pkg::*;

    localparam int Words = (NUM_PAGES + 63) / 64;
    localparam int WW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int PW    = $clog2(NUM_PAGES) + 1;
    localparam int PgSh  = $clog2(PAGE_BYTES);
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam logic [64:0] CapPages = 65'(NUM_PAGES);

    t_state r_state, n_state;
    logic [PW-1:0] r_i, n_i;
    logic [PW-1:0] r_j, n_j;
    logic [PW-1:0] r_end, n_end;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_ap, n_ap;
    logic [CntW-1:0] r_free, n_free, r_total, n_total;
    logic [1:0] r_status, n_status;
    logic [PW-1:0] r_res, n_res;
    logic [WW-1:0] r_clr, n_clr;

    logic          we;
    logic [WW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic [PW-1:0] pg;
    logic          bit_v;

    logic [63:0]   up_b, end_b;
    logic [64:0]   sp, ep;
    logic [29:0]   al_pg;
    logic [PW-1:0] ap_in;
    logic [PW:0]   fit;
    logic [PW-1:0] first_i;

    pba_ram #(.Width(64), .Depth(Words)) u_map (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction
    function automatic logic [CntW-1:0] sat_dec(input logic [CntW-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    // shared page pointer
    assign pg    = r_i + r_j;
    assign raddr = WW'(pg >> 6);
    assign bit_v = rdata[pg[5:0]];

    always_comb begin
        up_b  = i_address + 64'(PAGE_BYTES - 1);
        end_b = i_address + i_region_length;
        sp    = 65'(up_b >> PgSh);
        ep    = 65'(end_b >> PgSh);
        if (ep > CapPages) ep = CapPages;
        // an alignment past the map allows only the start at page zero
        al_pg = i_align_bytes >> PgSh;
        if (i_align_bytes < 30'(PAGE_BYTES)) ap_in = PW'(1);
        else if (al_pg > 30'(NUM_PAGES)) ap_in = PW'(NUM_PAGES);
        else ap_in = PW'(al_pg);
        fit = {1'b0, r_i} + {1'b0, r_cnt};
        first_i = r_i;
        for (int b = 63; b >= 0; b--)
            if (rdata[b]) first_i = {r_i[PW-1:6], 6'(b)};
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_end = r_end; n_cnt = r_cnt; n_ap = r_ap;
        n_free = r_free; n_total = r_total; n_status = r_status;
        n_res = r_res; n_clr = r_clr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == WW'(Words - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_status = StOk; n_res = '0;
                    n_i = '0; n_j = '0;
                    unique case (i_op)
                        OpAdd: begin
                            n_i = PW'(sp); n_end = PW'(ep);
                            n_state = (i_region_usable && sp < ep) ? S_ADD_RD : S_OUT;
                        end
                        OpAlloc: n_state = S_ONE_RD;
                        OpRun: begin
                            n_cnt = PW'(i_run_pages); n_ap = ap_in;
                            if (i_run_pages == '0 || 32'(i_run_pages) > NUM_PAGES) begin
                                n_status = StNoFree; n_state = S_OUT;
                            end else n_state = S_RUN_RD;
                        end
                        OpFree: begin
                            n_i = PW'(i_address >> PgSh);
                            if (i_address[PgSh-1:0] != '0 ||
                                (i_address >> PgSh) >= 64'(NUM_PAGES)) begin
                                n_status = StBadFree; n_state = S_OUT;
                            end else n_state = S_FREE_RD;
                        end
                    endcase
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: begin
                n_free = sat_inc(r_free); n_total = sat_inc(r_total);
                n_i = r_i + 1'b1;
                n_state = (r_i + 1'b1 < r_end) ? S_ADD_RD : S_OUT;
            end
            S_ONE_RD: n_state = S_ONE_CHK;
            S_ONE_CHK: begin
                if (rdata != '0) begin
                    if (first_i >= PW'(NUM_PAGES)) begin
                        n_status = StNoFree; n_state = S_OUT;
                    end else begin
                        n_i = first_i; n_res = first_i; n_cnt = PW'(1); n_j = '0;
                        n_state = S_CLR_RD;
                    end
                end else if (r_i[PW-1:6] == (PW-6)'(Words - 1)) begin
                    n_status = StNoFree; n_state = S_OUT;
                end else begin
                    n_i = r_i + PW'(64); n_state = S_ONE_RD;
                end
            end
            S_RUN_RD: begin
                if (fit > (PW+1)'(NUM_PAGES)) begin
                    n_status = StNoFree; n_state = S_OUT;
                end else n_state = S_RUN_CHK;
            end
            S_RUN_CHK: begin
                if (!bit_v) begin
                    // next aligned start past the used page
                    n_end = pg + 1'b1; n_j = '0; n_i = r_i + r_ap;
                    n_state = S_RUN_SKIP;
                end else if (r_j + 1'b1 == r_cnt) begin
                    n_j = '0; n_res = r_i; n_state = S_CLR_RD;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_RUN_RD;
                end
            end
            S_RUN_SKIP: begin
                if (r_i < r_end) n_i = r_i + r_ap;
                else n_state = S_RUN_RD;
            end
            S_CLR_RD: n_state = S_CLR_WR;
            S_CLR_WR: begin
                n_free = sat_dec(r_free);
                n_j = r_j + 1'b1;
                n_state = (r_j + 1'b1 < r_cnt) ? S_CLR_RD : S_OUT;
            end
            S_FREE_RD: n_state = S_FREE_CHK;
            S_FREE_CHK: begin
                if (bit_v) n_status = StBadFree;
                else n_free = sat_inc(r_free);
                n_state = S_OUT;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // map write port
    always_comb begin
        we    = 1'b0;
        waddr = raddr;
        wdata = rdata;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1; waddr = r_clr; wdata = '0;
            end
            S_ADD_WR: begin
                we = 1'b1; wdata[pg[5:0]] = 1'b1;
            end
            S_CLR_WR: begin
                we = 1'b1; wdata[pg[5:0]] = 1'b0;
            end
            S_FREE_CHK: begin
                we = !bit_v; wdata[pg[5:0]] = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_free <= '0; r_total <= '0;
            r_i <= '0; r_j <= '0; r_end <= '0; r_cnt <= '0; r_ap <= '0;
            r_status <= StOk; r_res <= '0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_free <= n_free;
            r_total <= n_total; r_end <= n_end; r_cnt <= n_cnt;
            r_i <= n_i; r_j <= n_j; r_ap <= n_ap; r_status <= n_status;
            r_res <= n_res;
        end
    end

    always_comb begin
        o_stall        = (r_state != S_IDLE);
        o_valid        = (r_state == S_OUT);
        o_status       = r_status;
        o_page_address = (r_status == StOk) ? AddrOutW'(64'(r_res) << PgSh) : '0;
        o_free_count   = r_free;
        o_total_count  = r_total;
    end
endmodule
`default_nettype wire

>>> verif/page_bitmap_allocator_checker.sv
`timescale 1ns / 100ps
module page_bitmap_allocator_checker
    import pba_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                o_stall,
    input  wire logic [1:0]          i_op,
    input  wire logic [63:0]         i_address,
    input  wire logic [63:0]         i_region_length,
    input  wire logic                i_region_usable,
    input  wire logic [17:0]         i_run_pages,
    input  wire logic [29:0]         i_align_bytes,
    input  wire logic                o_valid,
    input  wire logic                i_stall,
    input  wire logic [1:0]          o_status,
    input  wire logic [AddrOutW-1:0] o_page_address,
    input  wire logic [CntW-1:0]     o_free_count,
    input  wire logic [CntW-1:0]     o_total_count,
    output int                       o_errors,
    output int                       o_pending
);
    localparam longint unsigned NPages = NumPagesDef;
    localparam longint unsigned PgBytes = PageBytesDef;
    localparam longint unsigned CapBytes = NPages * PgBytes;
    localparam int CntMax = (1 << CntW) - 1;

    typedef struct packed {
        logic [1:0]          status;
        logic [AddrOutW-1:0] page_address;
        logic [CntW-1:0]     free_count;
        logic [CntW-1:0]     total_count;
    } alloc_word_t;

    bit          frame_free [NumPagesDef];
    int          free_cnt;
    int          total_cnt;
    alloc_word_t expected_words[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_words.size();

    initial begin
        foreach (frame_free[k]) frame_free[k] = 0;
        free_cnt  = 0;
        total_cnt = 0;
        errors    = 0;
    end

    function automatic int sat_up(int v);
        return (v < CntMax) ? v + 1 : CntMax;
    endfunction

    function automatic alloc_word_t allocate(logic [1:0] op, logic [63:0] addr,
            logic [63:0] len, logic usable, logic [17:0] run, logic [29:0] align);
        alloc_word_t     w;
        logic [63:0]     start_b;
        logic [63:0]     end_b;
        longint unsigned i;
        longint unsigned j;
        longint unsigned ap;
        longint unsigned cnt;
        longint unsigned idx;
        bit              found;
        w = '0;
        found = 0;
        idx = 0;
        case (op)
            OpAdd: begin
                if (usable) begin
                    start_b = (addr + (PgBytes - 1)) & ~(PgBytes - 1);
                    end_b = (addr + len) & ~(PgBytes - 1);
                    if (end_b > CapBytes) end_b = CapBytes;
                    if (start_b < end_b) begin
                        for (i = start_b / PgBytes; i < end_b / PgBytes; i++) begin
                            frame_free[i] = 1;
                            free_cnt  = sat_up(free_cnt);
                            total_cnt = sat_up(total_cnt);
                        end
                    end
                end
            end
            OpAlloc: begin
                for (i = 0; i < NPages && !found; i++) begin
                    if (frame_free[i]) begin
                        found = 1;
                        idx = i;
                    end
                end
                if (found) begin
                    frame_free[idx] = 0;
                    if (free_cnt > 0) free_cnt--;
                    w.page_address = AddrOutW'(idx * PgBytes);
                end else begin
                    w.status = StNoFree;
                end
            end
            OpRun: begin
                cnt = run;
                ap = (align < PgBytes) ? 1 : align / PgBytes;
                i = 0;
                if (cnt != 0 && cnt <= NPages) begin
                    while (!found && i + cnt <= NPages) begin
                        if (i % ap != 0) begin
                            i += ap - (i % ap);
                            continue;
                        end
                        for (j = 0; j < cnt; j++)
                            if (!frame_free[i + j]) break;
                        if (j == cnt) begin
                            found = 1;
                            idx = i;
                        end else begin
                            i += j + 1;
                        end
                    end
                end
                if (found) begin
                    for (j = 0; j < cnt; j++) begin
                        frame_free[idx + j] = 0;
                        if (free_cnt > 0) free_cnt--;
                    end
                    w.page_address = AddrOutW'(idx * PgBytes);
                end else begin
                    w.status = StNoFree;
                end
            end
            default: begin
                idx = addr / PgBytes;
                if (addr % PgBytes != 0 || idx >= NPages || frame_free[idx]) begin
                    w.status = StBadFree;
                end else begin
                    frame_free[idx] = 1;
                    free_cnt = sat_up(free_cnt);
                end
            end
        endcase
        w.free_count  = CntW'(free_cnt);
        w.total_count = CntW'(total_cnt);
        return w;
    endfunction

    always @(posedge i_clk) begin
        alloc_word_t exp_w;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_words.push_back(allocate(i_op, i_address, i_region_length,
                    i_region_usable, i_run_pages, i_align_bytes));
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word: st=%0d addr=%h free=%0d total=%0d",
                            o_status, o_page_address, o_free_count, o_total_count);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_status !== exp_w.status || o_page_address !== exp_w.page_address
                            || o_free_count !== exp_w.free_count
                            || o_total_count !== exp_w.total_count) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp st=%0d addr=%h free=%0d total=%0d",
                                " got st=%0d addr=%h free=%0d total=%0d"},
                                exp_w.status, exp_w.page_address, exp_w.free_count,
                                exp_w.total_count, o_status, o_page_address,
                                o_free_count, o_total_count);
                    end
                end
            end
        end
    end
endmodule

>>> verif/tb_page_bitmap_allocator.sv
`timescale 1ns / 100ps
module tb_page_bitmap_allocator;
    import pba_pkg::*;

    localparam longint unsigned PgBytes = PageBytesDef;
    localparam longint unsigned CapBytes = longint'(NumPagesDef) * PgBytes;
    localparam int Window = 1024;
    localparam longint CycleLimit = 40000000;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_stall;
    logic [1:0]          i_op = OpAdd;
    logic [63:0]         i_address = '0;
    logic [63:0]         i_region_length = '0;
    logic                i_region_usable = 0;
    logic [17:0]         i_run_pages = '0;
    logic [29:0]         i_align_bytes = '0;
    logic                o_valid;
    logic                i_stall = 0;
    logic [1:0]          o_status;
    logic [AddrOutW-1:0] o_page_address;
    logic [CntW-1:0]     o_free_count;
    logic [CntW-1:0]     o_total_count;
    int                  errors;
    int                  pending;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    logic   hold_req = 0;
    int     hold_left = 0;
    longint cycles = 0;

    page_bitmap_allocator dut (.*);

    page_bitmap_allocator_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_address, .i_region_length,
        .i_region_usable, .i_run_pages, .i_align_bytes, .o_valid, .i_stall, .o_status,
        .o_page_address, .o_free_count, .o_total_count,
        .o_errors(errors), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1;
        end else if (hold_req) begin
            hold_left <= 300;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send(logic [1:0] op, logic [63:0] addr, logic [63:0] len,
            logic [63:0] usable, logic [63:0] run, logic [63:0] align);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_op <= op;
        i_address <= addr;
        i_region_length <= len;
        i_region_usable <= usable[0];
        i_run_pages <= run[17:0];
        i_align_bytes <= align[29:0];
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] window_addr();
        return longint'($urandom_range(0, Window)) * PgBytes;
    endfunction

    task automatic random_word();
        int          pick;
        logic [63:0] align;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            send(OpAdd, window_addr() + (($urandom_range(0, 3) == 0)
                    ? 64'($urandom_range(0, 4095)) : 64'd0),
                64'($urandom_range(0, 48 * 4096)), 64'($urandom_range(0, 7) != 0),
                64'($urandom), 64'($urandom));
        end else if (pick < 32) begin
            send(OpAdd, rand64(), rand64(), 64'($urandom), 64'($urandom), 64'($urandom));
        end else if (pick < 55) begin
            send(OpAlloc, rand64(), rand64(), 64'($urandom), 64'($urandom), 64'($urandom));
        end else if (pick < 66) begin
            align = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 4095))
                : 64'd4096 << $urandom_range(0, 4);
            send(OpRun, rand64(), rand64(), 64'($urandom), 64'($urandom_range(1, 8)), align);
        end else if (pick < 76) begin
            align = 64'($urandom) | (64'd1 << $urandom_range(20, 29));
            send(OpRun, rand64(), rand64(), 64'($urandom), 64'($urandom), align);
        end else if (pick < 94) begin
            send(OpFree, window_addr(), rand64(), 64'($urandom), 64'($urandom), 64'($urandom));
        end else begin
            send(OpFree, rand64(), rand64(), 64'($urandom), 64'($urandom), 64'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // empty map
        send(OpAlloc, 0, 0, 0, 0, 0);
        send(OpRun, 0, 0, 0, 1, 64'd1 << 29);
        send(OpFree, 0, 0, 0, 0, 0);
        // regions: ignored, wrapping, clamped at the cap, normal, shorter than a page
        send(OpAdd, 0, 64'd64 * PgBytes, 0, 0, 0);
        send(OpAdd, 64'hFFFF_FFFF_FFFF_FF00, 64'd512, 1, 0, 0);
        send(OpAdd, '1, '1, 1, '1, '1);
        send(OpAdd, CapBytes - 8 * PgBytes, '1, 1, 0, 0);
        send(OpAdd, 64'd1, 64'd40 * PgBytes, 1, 0, 0);
        send(OpAdd, 0, PgBytes - 1, 1, 0, 0);
        // runs: zero length, oversized, all-ones, aligned, skip past used
        send(OpRun, 0, 0, 0, 0, 0);
        send(OpRun, 0, 0, 0, 64'd131073, 0);
        send(OpRun, 0, 0, 0, '1, '1);
        send(OpRun, 0, 0, 0, 64'd131072, 64'd1 << 29);
        send(OpAlloc, 0, 0, 0, 0, 0);
        send(OpRun, 0, 0, 0, 3, 64'd8192);
        send(OpRun, 0, 0, 0, 5, 64'd4095);
        send(OpRun, 0, 0, 0, 4, 64'd16384);
        send(OpRun, 0, 0, 0, 2, 64'd1 << 29);
        // frees: unaligned, beyond the map, already free, valid, all-ones
        send(OpFree, 64'd4097, 0, 0, 0, 0);
        send(OpFree, CapBytes, 0, 0, 0, 0);
        send(OpFree, CapBytes - PgBytes, 0, 0, 0, 0);
        send(OpFree, PgBytes, 0, 0, 0, 0);
        send(OpFree, PgBytes, 0, 0, 0, 0);
        send(OpFree, '1, '1, 1, '1, '1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (phase == 2) begin
                hold_req <= 1;
                @(posedge i_clk);
                hold_req <= 0;
            end
            for (int n = 0; n < 95; n++) begin
                random_word();
                if (phase == 1 && n == 40) drain();
            end
        end

        // counters up to saturation with the whole map added twice
        send(OpAdd, 0, CapBytes, 1, 0, 0);
        send(OpAdd, 0, CapBytes, 1, 0, 0);
        for (int n = 0; n < 6; n++) random_word();

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> page_bitmap_allocator.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/page_bitmap_allocator.sv
verif/page_bitmap_allocator_checker.sv
verif/tb_page_bitmap_allocator.sv
